>>> sv/pip_pkg.sv
package pip_pkg;

    localparam int CoordW = 16;
    localparam int DiffW  = CoordW + 1;
    localparam int ProdW  = 2 * DiffW;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    typedef struct packed {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
    } t_vertex;

    // one edge handed to the crossing unit: current vertex i, previous vertex j
    typedef struct packed {
        logic    valid;
        t_vertex cur;
        t_vertex prev;
        t_vertex pt;
    } t_edge_req;

endpackage

>>> sv/point_in_polygon_test_core.sv
// Channel   | Handshake                  | Payload
// ----------+----------------------------+-------------------------------
// input     | i_in_valid / o_in_ready    | i_op, i_x, i_y
// output    | o_out_valid / i_out_ready  | o_inside_res, o_status
//
// Clear, append and unused codes need no further steps; the result lands in the
// output register on the transfer itself.
// A query of n stored vertices makes n + 1 reads of the vertex memory (last
// vertex first, then every vertex in order) that pass through the registered
// memory read and three stages of the edge unit, one edge per cycle.
// Reset (synchronous, active low) empties the table and the output register;
// the vertex memory itself is not cleared.
// A stalled output holds o_in_ready low; a new transfer is taken only once the
// pending result is gone or leaves in the same cycle.
module point_in_polygon_test_core #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_op,
    input  logic signed [15:0]         i_x,
    input  logic signed [15:0]         i_y,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_inside_res,
    output logic                       o_status
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);   // vertex count
    localparam int IW = $clog2(MAX_VERTICES + 2);   // read issue counter

    typedef enum logic {
        ST_IDLE,
        ST_QUERY
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [IW-1:0]       r_issue, n_issue;
    logic [CW-1:0]       r_done, n_done;
    logic                r_inside, n_inside;
    pip_pkg::t_vertex    r_pt, n_pt;
    pip_pkg::t_vertex    r_prev, n_prev;
    logic                r_rd_valid, n_rd_valid;
    logic                r_rd_first, n_rd_first;
    logic                r_out_valid, n_out_valid;
    logic                r_out_inside, n_out_inside;
    logic                r_out_status, n_out_status;

    logic                in_xfer;
    logic                full;
    logic                mem_we;
    logic [AW-1:0]       mem_raddr;
    logic [CW-1:0]       last_idx;
    logic [IW-1:0]       issue_m1;
    logic                rd_en;
    pip_pkg::t_vertex    wdata;
    pip_pkg::t_vertex    rdata;
    pip_pkg::t_edge_req  edge_req;
    logic                edge_valid;
    logic                edge_cross;

    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign full       = (r_count >= CW'(MAX_VERTICES));
    assign mem_we     = in_xfer && (i_op == pip_pkg::OP_APPEND) && !full;
    assign wdata      = '{x: i_x, y: i_y};

    // read order: the last vertex first, then vertex 0 upward
    assign last_idx  = r_count - 1'b1;
    assign issue_m1  = r_issue - 1'b1;
    assign mem_raddr = (r_issue == '0) ? last_idx[AW-1:0] : issue_m1[AW-1:0];
    assign rd_en     = (r_state == ST_QUERY) && (r_issue <= IW'(r_count));

    // appends and queries never overlap, so reads never see a write in flight
    pip_vertex_mem #(
        .DEPTH (MAX_VERTICES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rdata)
    );

    // the first word read only primes the previous-vertex register
    assign edge_req = '{valid: r_rd_valid && !r_rd_first,
                        cur:   rdata,
                        prev:  r_prev,
                        pt:    r_pt};

    pip_edge_unit u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (edge_req),
        .o_valid (edge_valid),
        .o_cross (edge_cross)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_issue      = r_issue;
        n_done       = r_done;
        n_inside     = r_inside;
        n_pt         = r_pt;
        n_prev       = r_rd_valid ? rdata : r_prev;
        n_rd_valid   = rd_en;
        n_rd_first   = (r_issue == '0);
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_inside = r_out_inside;
        n_out_status = r_out_status;

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    // default result for everything but a running query
                    n_out_valid  = 1'b1;
                    n_out_inside = 1'b0;
                    n_out_status = 1'b0;
                    case (i_op)
                        pip_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        pip_pkg::OP_APPEND: begin
                            if (full) begin
                                n_out_status = 1'b1;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        pip_pkg::OP_QUERY: begin
                            if (r_count != '0) begin
                                n_out_valid = 1'b0;
                                n_state     = ST_QUERY;
                                n_issue     = '0;
                                n_done      = '0;
                                n_inside    = 1'b0;
                                n_pt        = wdata;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_QUERY: begin
                if (rd_en) begin
                    n_issue = r_issue + 1'b1;
                end
                if (edge_valid) begin
                    n_done   = r_done + 1'b1;
                    n_inside = r_inside ^ edge_cross;
                    // last edge retired: post the parity
                    if (r_done + 1'b1 == r_count) begin
                        n_state      = ST_IDLE;
                        n_out_valid  = 1'b1;
                        n_out_inside = r_inside ^ edge_cross;
                        n_out_status = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_issue     <= '0;
            r_done      <= '0;
            r_rd_valid  <= 1'b0;
            r_rd_first  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_done      <= n_done;
            r_rd_valid  <= n_rd_valid;
            r_rd_first  <= n_rd_first;
            r_out_valid <= n_out_valid;
        end
        r_inside     <= n_inside;
        r_pt         <= n_pt;
        r_prev       <= n_prev;
        r_out_inside <= n_out_inside;
        r_out_status <= n_out_status;
    end

    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_out_inside;
    assign o_status     = r_out_status;

endmodule

>>> sv/pip_vertex_mem.sv
module pip_vertex_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  pip_pkg::t_vertex i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output pip_pkg::t_vertex o_rdata
);

    pip_pkg::t_vertex r_mem [DEPTH];
    pip_pkg::t_vertex r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/pip_edge_unit.sv
module pip_edge_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pip_pkg::t_edge_req i_req,
    output logic              o_valid,
    output logic              o_cross
);

    // stage A: differences and straddle test
    logic                               r_a_valid;
    logic                               r_a_straddle;
    logic                               r_a_dy_neg;
    logic signed [pip_pkg::DiffW-1:0]   r_a_dxp;
    logic signed [pip_pkg::DiffW-1:0]   r_a_dy;
    logic signed [pip_pkg::DiffW-1:0]   r_a_dxe;
    logic signed [pip_pkg::DiffW-1:0]   r_a_dyp;
    // stage B: products
    logic                               r_b_valid;
    logic                               r_b_straddle;
    logic                               r_b_dy_neg;
    logic signed [pip_pkg::ProdW-1:0]   r_b_lhs;
    logic signed [pip_pkg::ProdW-1:0]   r_b_rhs;
    // stage C: verdict
    logic                               r_c_valid;
    logic                               r_c_cross;

    logic signed [pip_pkg::DiffW-1:0]   xi, yi, xj, yj, px, py;
    logic                               straddle;

    always_comb begin
        xi = pip_pkg::DiffW'(i_req.cur.x);
        yi = pip_pkg::DiffW'(i_req.cur.y);
        xj = pip_pkg::DiffW'(i_req.prev.x);
        yj = pip_pkg::DiffW'(i_req.prev.y);
        px = pip_pkg::DiffW'(i_req.pt.x);
        py = pip_pkg::DiffW'(i_req.pt.y);
        straddle = ((yi <= py) && (py < yj)) || ((yj <= py) && (py < yi));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= i_req.valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
        r_a_straddle <= straddle;
        r_a_dy_neg   <= (yj < yi);
        r_a_dxp      <= px - xi;
        r_a_dy       <= yj - yi;
        r_a_dxe      <= xj - xi;
        r_a_dyp      <= py - yi;

        r_b_straddle <= r_a_straddle;
        r_b_dy_neg   <= r_a_dy_neg;
        r_b_lhs      <= pip_pkg::ProdW'(r_a_dxp) * pip_pkg::ProdW'(r_a_dy);
        r_b_rhs      <= pip_pkg::ProdW'(r_a_dxe) * pip_pkg::ProdW'(r_a_dyp);

        // flip the compare when the edge runs downward
        r_c_cross <= r_b_straddle &&
                     (r_b_dy_neg ? (r_b_lhs > r_b_rhs) : (r_b_lhs < r_b_rhs));
    end

    assign o_valid = r_c_valid;
    assign o_cross = r_c_cross;

endmodule

>>> sv/pip_core_checker.sv
module pip_core_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_op,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_inside_res,
    input logic        o_status
);

    // hold a pending result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // block new transfers while a result waits
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while output stalled");

    // a clear answers at once with zeros
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_op == pip_pkg::OP_CLEAR)
        |=> o_out_valid && !o_inside_res && !o_status)
        else $error("clear gave a wrong result");

    // a dropped vertex never reports inside
    a_status_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_status && o_inside_res))
        else $error("status and inside both set");

endmodule

bind point_in_polygon_test_core pip_core_checker u_pip_chk (.*);
